[hdl/mrx_pkg.sv]
// ---------------------------------------------------------------------------
// mrx_pkg: shared types and codes for the MQTT receive packet parser
// Holds the parse phase and result kind encodings, the packet type codes and
// the item and result records passed between the parser and the top level.
// ---------------------------------------------------------------------------
package mrx_pkg;

    localparam int LEN_W = 28;

    // Parse phase of the receive stream
    typedef enum logic [2:0] {
        PH_TYPE,
        PH_LENGTH,
        PH_VARHDR,
        PH_TOPICLEN,
        PH_TOPIC,
        PH_PKTID,
        PH_PAYLOAD
    } phase_t;

    // Result kind codes as seen on the output port
    typedef enum logic [3:0] {
        K_NONE      = 4'd0,
        K_TOPIC     = 4'd1,
        K_READY     = 4'd2,
        K_PAYLOAD   = 4'd3,
        K_CONNACK   = 4'd4,
        K_ACK       = 4'd5,
        K_SUBACK    = 4'd6,
        K_PUBACK    = 4'd7,
        K_PUBREC    = 4'd8,
        K_PUBCOMP   = 4'd9,
        K_MALFORMED = 4'd10
    } kind_t;

    // Control packet type codes from the fixed header
    localparam logic [3:0] T_CONNACK  = 4'd2;
    localparam logic [3:0] T_PUBLISH  = 4'd3;
    localparam logic [3:0] T_PUBACK   = 4'd4;
    localparam logic [3:0] T_PUBREC   = 4'd5;
    localparam logic [3:0] T_PUBREL   = 4'd6;
    localparam logic [3:0] T_PUBCOMP  = 4'd7;
    localparam logic [3:0] T_SUBACK   = 4'd9;
    localparam logic [3:0] T_UNSUBACK = 4'd11;
    localparam logic [3:0] T_PINGRESP = 4'd13;

    // Required fixed header flags of PUBREL
    localparam logic [3:0] PUBREL_FLAGS = 4'h2;

    // Last remaining-length byte position before the length is malformed
    localparam logic [2:0] LEN_BYTES_MAX = 3'd4;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  rx_byte;
        logic [15:0] awaited_packet_id;
        logic        publish_in_progress;
    } item_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       data_byte;
        logic [15:0]      packet_id;
        logic [LEN_W-1:0] payload_length;
        logic [1:0]       qos;
        logic             dup;
        logic             retain;
        logic [7:0]       return_code;
        logic             last;
    } result_t;

    // Results of one parse step: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } step_res_t;

    function automatic result_t make_result(
        input kind_t            k,
        input logic [7:0]       data,
        input logic [15:0]      pid,
        input logic [LEN_W-1:0] plen,
        input logic [1:0]       q,
        input logic             du,
        input logic             re,
        input logic [7:0]       rc
    );
        result_t r;
        r.kind           = k;
        r.data_byte      = data;
        r.packet_id      = pid;
        r.payload_length = plen;
        r.qos            = q;
        r.dup            = du;
        r.retain         = re;
        r.return_code    = rc;
        r.last           = 1'b0;
        return r;
    endfunction

endpackage

[hdl/mqtt_rx_packet_parser_top.sv]
// ---------------------------------------------------------------------------
// mqtt_rx_packet_parser_top: client-side MQTT receive packet parser
// Takes one received stream byte (or a link-lost command) per input transfer
// and delivers the decoded results: topic and payload bytes, message ready,
// CONNACK and SUBACK codes, matched acknowledgements, reply requests and
// malformed-packet reports.
//
// Input channel: in_valid / in_stall with cmd, rx_byte, awaited_packet_id and
// publish_in_progress. Output channel: out_valid / out_stall with one result
// per transfer; last marks the final result caused by one input item.
// An item is held in an input register and parsed from there; once it
// advances, its results are registered in a two-entry output buffer, whose
// head drives out_valid and the result fields.
// One byte is taken every cycle while the receiver keeps up. Items that give
// two results (last topic byte of a QoS 0 publish, packet id or last payload
// byte with a reply) take two buffer entries and can hold the input until
// the buffer drains. Items with no result use no output slot.
// When the receiver stalls, results wait in the output buffer and in_stall
// rises while the buffer has no room for the held item's results.
// Reset clears the parser to packet start and empties the buffer.
// ---------------------------------------------------------------------------
module mqtt_rx_packet_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  rx_byte,
    input  logic [15:0] awaited_packet_id,
    input  logic        publish_in_progress,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  kind,
    output logic [7:0]  data_byte,
    output logic [15:0] packet_id,
    output logic [27:0] payload_length,
    output logic [1:0]  qos,
    output logic        dup,
    output logic        retain,
    output logic [7:0]  return_code,
    output logic        last
);
    import mrx_pkg::*;

    item_t      item_reg;
    logic       item_valid_reg, item_valid_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic [1:0] cnt_reg, cnt_next;
    step_res_t  step_res;
    logic       in_xfer;
    logic       pop;
    logic [1:0] keep;
    logic       advance;

    mrx_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_reg),
        .step     (advance),
        .step_res (step_res)
    );

    // Handshake and buffer space
    always_comb
    begin
        pop      = (cnt_reg != 2'd0) && !out_stall;
        keep     = cnt_reg - {1'b0, pop};
        advance  = item_valid_reg && (({1'b0, keep} + {1'b0, step_res.count}) <= 3'd2);
        in_stall = item_valid_reg && !advance;
        in_xfer  = in_valid && !in_stall;
        item_valid_next = in_xfer ? 1'b1 : (advance ? 1'b0 : item_valid_reg);
    end

    // Output buffer: shift out the head, append the step's results
    always_comb
    begin
        slot0_next = pop ? slot1_reg : slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = keep;
        if (advance)
        begin
            case (keep)
                2'd0:
                begin
                    slot0_next = step_res.first;
                    slot1_next = step_res.second;
                end
                2'd1:
                begin
                    slot1_next = step_res.first;
                end
                default: ;
            endcase
            cnt_next = keep + step_res.count;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    // Payload registers: input item and result slots
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.cmd                 <= cmd;
            item_reg.rx_byte             <= rx_byte;
            item_reg.awaited_packet_id   <= awaited_packet_id;
            item_reg.publish_in_progress <= publish_in_progress;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // Drive the output channel from the buffer head
    assign out_valid      = (cnt_reg != 2'd0);
    assign kind           = slot0_reg.kind;
    assign data_byte      = slot0_reg.data_byte;
    assign packet_id      = slot0_reg.packet_id;
    assign payload_length = slot0_reg.payload_length;
    assign qos            = slot0_reg.qos;
    assign dup            = slot0_reg.dup;
    assign retain         = slot0_reg.retain;
    assign return_code    = slot0_reg.return_code;
    assign last           = slot0_reg.last;

    // A delivered result always carries a real kind
    a_kind_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind != K_NONE))
        else $error("result delivered with no kind");

    // The companion of a non-final result is already buffered
    a_pair_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> out_valid)
        else $error("second result of an item missing");

    // An item only waits while the buffer holds results
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !advance) |-> (cnt_reg != 2'd0))
        else $error("item held with an empty output buffer");

endmodule

[hdl/mrx_parse.sv]
// ---------------------------------------------------------------------------
// mrx_parse: packet parse state and per-byte result logic
// Holds the parser state. From the registered item and the current state it
// forms up to two results in one pass; the state advances when step is high.
// ---------------------------------------------------------------------------
module mrx_parse (
    input  logic               clk,
    input  logic               rst_n,
    input  mrx_pkg::item_t     item,
    input  logic               step,
    output mrx_pkg::step_res_t step_res
);
    import mrx_pkg::*;

    phase_t           phase_reg,      phase_next;
    logic [3:0]       ptype_reg,      ptype_next;
    logic [3:0]       flags_reg,      flags_next;
    logic [LEN_W-1:0] rem_reg,        rem_next;
    logic [2:0]       lbc_reg,        lbc_next;
    logic [7:0]       hb_reg [3];
    logic [7:0]       hb_next [3];
    logic [1:0]       hbi_reg,        hbi_next;
    logic [15:0]      tlen_reg,       tlen_next;
    logic [15:0]      tseen_reg,      tseen_next;
    logic [1:0]       mqos_reg,       mqos_next;
    logic [1:0]       mflags_reg,     mflags_next;
    logic [15:0]      mpid_reg,       mpid_next;

    logic [7:0]       b;
    logic             hb_wr_en;
    logic [1:0]       hb_wr_idx;
    logic [15:0]      id_w;
    logic [1:0]       hbi_inc;
    logic [2:0]       lbc_inc;
    logic [15:0]      tseen_inc;
    logic [LEN_W-1:0] len_part;
    logic [LEN_W-1:0] len_acc;
    logic [LEN_W-1:0] topic_need;
    logic [LEN_W-1:0] rem_dec;
    logic             reply_en;
    kind_t            reply_kind;
    result_t          res_a;
    result_t          res_b;
    logic [1:0]       res_n;

    function automatic logic header_bad(
        input logic [3:0]       t,
        input logic [3:0]       f,
        input logic [LEN_W-1:0] len
    );
        logic bad;
        case (t)
            T_CONNACK, T_PUBACK, T_PUBREC, T_PUBCOMP, T_UNSUBACK:
                bad = (f != 4'd0) || (len != LEN_W'(2));
            T_PUBLISH:
                bad = (f[2:1] == 2'b11);
            T_PUBREL:
                bad = (f != PUBREL_FLAGS) || (len != LEN_W'(2));
            T_SUBACK:
                bad = (f != 4'd0) || (len != LEN_W'(3));
            T_PINGRESP:
                bad = (f != 4'd0) || (len != '0);
            default:
                bad = 1'b1;
        endcase
        return bad;
    endfunction

    // Write-through view of the header byte store and shared increments
    always_comb
    begin
        b         = item.rx_byte;
        hb_wr_en  = !item.cmd && (((phase_reg == PH_VARHDR) && (hbi_reg != 2'd3))
                    || (phase_reg == PH_TOPICLEN) || (phase_reg == PH_PKTID));
        hb_wr_idx = (phase_reg == PH_VARHDR) ? hbi_reg : {1'b0, hbi_reg[0]};
        for (int i = 0; i < 3; i++)
        begin
            hb_next[i] = (hb_wr_en && (hb_wr_idx == 2'(i))) ? b : hb_reg[i];
        end
        id_w      = {hb_next[0], hb_next[1]};
        hbi_inc   = hbi_reg + 2'd1;
        lbc_inc   = lbc_reg + 3'd1;
        tseen_inc = tseen_reg + 16'd1;

        // Place the seven length bits of this byte at their group
        case (lbc_reg[1:0])
            2'd0:    len_part = LEN_W'(b[6:0]);
            2'd1:    len_part = LEN_W'(b[6:0]) << 7;
            2'd2:    len_part = LEN_W'(b[6:0]) << 14;
            default: len_part = LEN_W'(b[6:0]) << 21;
        endcase
        len_acc    = rem_reg | len_part;
        topic_need = LEN_W'(id_w) + LEN_W'(2) + ((mqos_reg != 2'd0) ? LEN_W'(2) : '0);
        rem_dec    = (rem_reg != '0) ? rem_reg - LEN_W'(1) : '0;

        reply_en   = (mqos_reg == 2'd1) || (mqos_reg == 2'd2);
        reply_kind = (mqos_reg == 2'd1) ? K_PUBACK : K_PUBREC;
    end

    // Next state and results of one step
    always_comb
    begin
        phase_next  = phase_reg;
        ptype_next  = ptype_reg;
        flags_next  = flags_reg;
        rem_next    = rem_reg;
        lbc_next    = lbc_reg;
        hbi_next    = hbi_reg;
        tlen_next   = tlen_reg;
        tseen_next  = tseen_reg;
        mqos_next   = mqos_reg;
        mflags_next = mflags_reg;
        mpid_next   = mpid_reg;
        res_a       = make_result(K_NONE, '0, '0, '0, '0, 1'b0, 1'b0, '0);
        res_b       = res_a;
        res_n       = 2'd0;

        if (item.cmd)
        begin
            // Link lost: drop back to packet start
            phase_next = PH_TYPE;
        end
        else
        begin
            case (phase_reg)
                PH_TYPE:
                begin
                    ptype_next = b[7:4];
                    flags_next = b[3:0];
                    rem_next   = '0;
                    lbc_next   = '0;
                    phase_next = PH_LENGTH;
                end

                PH_LENGTH:
                begin
                    rem_next = len_acc;
                    lbc_next = lbc_inc;
                    if (b[7])
                    begin
                        if (lbc_inc >= LEN_BYTES_MAX)
                        begin
                            phase_next = PH_TYPE;
                            res_a      = make_result(K_MALFORMED, '0, '0, '0, '0,
                                                     1'b0, 1'b0, '0);
                            res_n      = 2'd1;
                        end
                    end
                    else if (header_bad(ptype_reg, flags_reg, len_acc))
                    begin
                        phase_next = PH_TYPE;
                        res_a      = make_result(K_MALFORMED, '0, '0, '0, '0,
                                                 1'b0, 1'b0, '0);
                        res_n      = 2'd1;
                    end
                    else
                    begin
                        hbi_next = '0;
                        if (ptype_reg == T_PUBLISH)
                        begin
                            mqos_next   = flags_reg[2:1];
                            mflags_next = {flags_reg[3], flags_reg[0]};
                            phase_next  = PH_TOPICLEN;
                        end
                        else if (len_acc == '0)
                        begin
                            phase_next = PH_TYPE;
                        end
                        else
                        begin
                            phase_next = PH_VARHDR;
                        end
                    end
                end

                PH_VARHDR:
                begin
                    hbi_next = hbi_inc;
                    if (LEN_W'(hbi_inc) == rem_reg)
                    begin
                        phase_next = PH_TYPE;
                        case (ptype_reg)
                            T_CONNACK:
                            begin
                                res_a = make_result(K_CONNACK, '0, '0, '0, '0,
                                                    1'b0, 1'b0, hb_next[1]);
                                res_n = 2'd1;
                            end
                            T_PUBACK, T_PUBREC, T_PUBCOMP, T_UNSUBACK:
                            begin
                                if (id_w == item.awaited_packet_id)
                                begin
                                    res_a = make_result(K_ACK, '0, id_w, '0, '0,
                                                        1'b0, 1'b0, '0);
                                    res_n = 2'd1;
                                end
                            end
                            T_PUBREL:
                            begin
                                if (!item.publish_in_progress)
                                begin
                                    res_a = make_result(K_PUBCOMP, '0, id_w, '0, '0,
                                                        1'b0, 1'b0, '0);
                                    res_n = 2'd1;
                                end
                            end
                            T_SUBACK:
                            begin
                                if (id_w == item.awaited_packet_id)
                                begin
                                    res_a = make_result(K_SUBACK, '0, id_w, '0, '0,
                                                        1'b0, 1'b0, hb_next[2]);
                                    res_n = 2'd1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                PH_TOPICLEN:
                begin
                    hbi_next = hbi_inc;
                    if (hbi_inc >= 2'd2)
                    begin
                        tlen_next = id_w;
                        if ((id_w == 16'd0) || (rem_reg < topic_need))
                        begin
                            phase_next = PH_TYPE;
                            res_a      = make_result(K_MALFORMED, '0, '0, '0, '0,
                                                     1'b0, 1'b0, '0);
                            res_n      = 2'd1;
                        end
                        else
                        begin
                            rem_next   = rem_reg - LEN_W'(2);
                            tseen_next = '0;
                            hbi_next   = '0;
                            phase_next = PH_TOPIC;
                        end
                    end
                end

                PH_TOPIC:
                begin
                    res_a      = make_result(K_TOPIC, b, '0, '0, '0, 1'b0, 1'b0, '0);
                    res_n      = 2'd1;
                    tseen_next = tseen_inc;
                    if (tseen_inc == tlen_reg)
                    begin
                        rem_next = rem_reg - LEN_W'(tlen_reg);
                        if (mqos_reg != 2'd0)
                        begin
                            hbi_next   = '0;
                            phase_next = PH_PKTID;
                        end
                        else
                        begin
                            res_b      = make_result(K_READY, '0, '0,
                                                     rem_reg - LEN_W'(tlen_reg), mqos_reg,
                                                     mflags_reg[1], mflags_reg[0], '0);
                            res_n      = 2'd2;
                            phase_next = (rem_reg != LEN_W'(tlen_reg)) ? PH_PAYLOAD
                                                                        : PH_TYPE;
                        end
                    end
                end

                PH_PKTID:
                begin
                    hbi_next = hbi_inc;
                    if (hbi_inc >= 2'd2)
                    begin
                        rem_next  = rem_reg - LEN_W'(2);
                        mpid_next = id_w;
                        res_a     = make_result(K_READY, '0, id_w, rem_reg - LEN_W'(2),
                                                mqos_reg, mflags_reg[1], mflags_reg[0], '0);
                        res_n     = 2'd1;
                        if (rem_reg == LEN_W'(2))
                        begin
                            if (reply_en)
                            begin
                                res_b = make_result(reply_kind, '0, id_w, '0, '0,
                                                    1'b0, 1'b0, '0);
                                res_n = 2'd2;
                            end
                            phase_next = PH_TYPE;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end

                PH_PAYLOAD:
                begin
                    res_a    = make_result(K_PAYLOAD, b, '0, '0, '0, 1'b0, 1'b0, '0);
                    res_n    = 2'd1;
                    rem_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        if (reply_en)
                        begin
                            res_b = make_result(reply_kind, '0, mpid_reg, '0, '0,
                                                1'b0, 1'b0, '0);
                            res_n = 2'd2;
                        end
                        phase_next = PH_TYPE;
                    end
                end

                default:
                begin
                    phase_next = PH_TYPE;
                end
            endcase
        end

        // Mark the final result of the step
        if (res_n == 2'd1)
        begin
            res_a.last = 1'b1;
        end
        else if (res_n == 2'd2)
        begin
            res_b.last = 1'b1;
        end

        step_res.count  = res_n;
        step_res.first  = res_a;
        step_res.second = res_b;
    end

    // Parser state, advanced once per stepped item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TYPE;
            ptype_reg  <= '0;
            flags_reg  <= '0;
            rem_reg    <= '0;
            lbc_reg    <= '0;
            hbi_reg    <= '0;
            tlen_reg   <= '0;
            tseen_reg  <= '0;
            mqos_reg   <= '0;
            mflags_reg <= '0;
            mpid_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            ptype_reg  <= ptype_next;
            flags_reg  <= flags_next;
            rem_reg    <= rem_next;
            lbc_reg    <= lbc_next;
            hbi_reg    <= hbi_next;
            tlen_reg   <= tlen_next;
            tseen_reg  <= tseen_next;
            mqos_reg   <= mqos_next;
            mflags_reg <= mflags_next;
            mpid_reg   <= mpid_next;
        end
    end

    // Header byte store: written before read, no reset
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            for (int i = 0; i < 3; i++)
            begin
                hb_reg[i] <= hb_next[i];
            end
        end
    end

endmodule
